@@ rtl/core/mcs_pkg.sv @@
package mcs_pkg;

    // display geometry
    localparam int MAX_ROWS      = 8;
    localparam int LINES_PER_ROW = 4;
    localparam int ENTRY_COUNT   = MAX_ROWS * LINES_PER_ROW;
    localparam int ENTRY_AW      = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

    // field widths
    localparam int OP_W     = 2;
    localparam int ROW_W    = 3;
    localparam int LINE_W   = 2;
    localparam int PIX_W    = 12;
    localparam int TIME_W   = 32;
    localparam int OFF_W    = 16;
    localparam int PHASE_W  = 2;
    localparam int RATE_W   = 8;
    localparam int PAUSE_W  = 16;
    localparam int ICONW_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // memory words: phase and stamp in one, started flag and offset in the other
    localparam int PS_W = PHASE_W + TIME_W;
    localparam int SO_W = 1 + OFF_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADVANCE   = 2'd0;
    localparam logic [OP_W-1:0] OP_RESET_ROW = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET_ALL = 2'd2;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_BEFORE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_SCROLL = 2'd1;
    localparam logic [PHASE_W-1:0] PH_AFTER  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_MS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ICON_WIDTH  = 2'd2;

    // configuration reset values
    localparam logic [RATE_W-1:0]  RST_SCROLL_RATE = 8'd2;
    localparam logic [PAUSE_W-1:0] RST_PAUSE_MS    = 16'd2000;
    localparam logic [ICONW_W-1:0] RST_ICON_WIDTH  = 8'd24;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } t_state;

    // table index of one row and line
    function automatic logic [ENTRY_AW-1:0] entry_idx(input logic [ROW_W-1:0] row,
                                                      input logic [LINE_W-1:0] line);
        int sum;
        sum = int'(row) * LINES_PER_ROW + int'(line);
        return ENTRY_AW'(sum);
    endfunction

endpackage

@@ rtl/core/mcs_ram.sv @@
module mcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/marquee_scroll_controller.sv @@
// Marquee scroll sequencer, one table entry per (row, line) of the display.
// Request channel: i_in_valid / o_in_stall with operation, row, line, text and
// window widths, icon and non-empty flags and the current time in ms. A request
// is taken when i_in_valid is high and o_in_stall is low.
// Result channel: o_out_valid / i_out_stall with offset, phase and icon flag;
// every request gives exactly one result, in request order.
// Configuration: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index selects
// scroll rate (0), pause in ms (1) or icon width (2); other indexes are dropped.
// The result is registered once the output register is free; the entry memories
// are read when a request is taken and written back as its result is registered,
// and the block takes no new request until that write is done.
// A finished result waits in the output register while the next request is
// taken; if the receiver still stalls when that second result is ready, the
// block holds it and stalls its own input until the register drains.
// Reset (i_rst_n low, synchronous) restores the configuration defaults and marks
// all entries as unwritten, so they read as wait-before, offset zero, stamp unset
// and not started; no clearing pass is needed.
module marquee_scroll_controller (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // requests
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [mcs_pkg::OP_W-1:0]         i_operation,
    input  logic [mcs_pkg::ROW_W-1:0]        i_row,
    input  logic [mcs_pkg::LINE_W-1:0]       i_line,
    input  logic [mcs_pkg::PIX_W-1:0]        i_text_width,
    input  logic                             i_text_nonempty,
    input  logic                             i_with_icon,
    input  logic [mcs_pkg::PIX_W-1:0]        i_window_width,
    input  logic [mcs_pkg::TIME_W-1:0]       i_now_ms,
    // results
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [mcs_pkg::OFF_W-1:0] o_scroll_offset,
    output logic [mcs_pkg::PHASE_W-1:0]      o_phase,
    output logic                             o_icon_shown,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mcs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mcs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mcs_pkg::*;

    // control
    t_state r_state, n_state;
    logic   in_take;
    logic   calc_done;

    // configuration registers
    logic [RATE_W-1:0]  r_scroll_rate;
    logic [PAUSE_W-1:0] r_pause_ms;
    logic [ICONW_W-1:0] r_icon_width;

    // latched request
    logic [OP_W-1:0]     r_op;
    logic [ROW_W-1:0]    r_row;
    logic [LINE_W-1:0]   r_line;
    logic [PIX_W-1:0]    r_text_width;
    logic                r_nonempty;
    logic                r_with_icon;
    logic [PIX_W-1:0]    r_window_width;
    logic [TIME_W-1:0]   r_now_ms;
    logic [ENTRY_AW-1:0] r_entry;
    logic                r_ps_vld_rd;
    logic                r_so_vld_rd;

    // written marks, one per entry for each memory
    logic [ENTRY_COUNT-1:0] r_ps_vld;
    logic [ENTRY_COUNT-1:0] r_so_vld;
    logic [ENTRY_COUNT-1:0] row_mask;

    // memory ports
    logic [ENTRY_AW-1:0] rd_addr;
    logic [PS_W-1:0]     ps_rdata, ps_wdata;
    logic [SO_W-1:0]     so_rdata, so_wdata;
    logic                mem_we;

    // entry as read
    logic [PHASE_W-1:0]      cur_phase;
    logic [TIME_W-1:0]       cur_stamp;
    logic signed [OFF_W-1:0] cur_off;
    logic                    cur_started;

    // step arithmetic
    logic                    icon;
    logic [PIX_W:0]          full_w;
    logic signed [PIX_W+1:0] to_scroll;
    logic signed [PIX_W+2:0] neg_scroll;
    logic                    do_scroll;
    logic [TIME_W-1:0]       elapsed;
    logic                    pause_over;
    logic signed [OFF_W:0]   off_sub;
    logic signed [OFF_W-1:0] off_sat;
    logic                    advance;

    // entry as written back
    logic [PHASE_W-1:0]      new_phase;
    logic [TIME_W-1:0]       new_stamp;
    logic signed [OFF_W-1:0] new_off;
    logic                    new_started;

    // result
    logic signed [OFF_W-1:0] res_off;
    logic [PHASE_W-1:0]      res_phase;
    logic                    res_icon;
    logic                    r_out_valid;
    logic signed [OFF_W-1:0] r_out_off;
    logic [PHASE_W-1:0]      r_out_phase;
    logic                    r_out_icon;

    // configuration port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_rate <= RST_SCROLL_RATE;
            r_pause_ms    <= RST_PAUSE_MS;
            r_icon_width  <= RST_ICON_WIDTH;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SCROLL_RATE: r_scroll_rate <= i_cfg_data[RATE_W-1:0];
                CFG_PAUSE_MS:    r_pause_ms    <= i_cfg_data[PAUSE_W-1:0];
                CFG_ICON_WIDTH:  r_icon_width  <= i_cfg_data[ICONW_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_CALC;
            ST_CALC: if (calc_done) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        calc_done  = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_CALC: calc_done  = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    assign in_take = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capture the request together with the written marks of its entry
    assign rd_addr = entry_idx(i_row, i_line);

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op           <= i_operation;
            r_row          <= i_row;
            r_line         <= i_line;
            r_text_width   <= i_text_width;
            r_nonempty     <= i_text_nonempty;
            r_with_icon    <= i_with_icon;
            r_window_width <= i_window_width;
            r_now_ms       <= i_now_ms;
            r_entry        <= rd_addr;
            r_ps_vld_rd    <= r_ps_vld[rd_addr];
            r_so_vld_rd    <= r_so_vld[rd_addr];
        end
    end

    // entry memories
    mcs_ram #(.WIDTH(PS_W), .DEPTH(ENTRY_COUNT)) u_ps_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_entry),
        .i_wdata (ps_wdata),
        .i_re    (in_take),
        .i_raddr (rd_addr),
        .o_rdata (ps_rdata)
    );

    mcs_ram #(.WIDTH(SO_W), .DEPTH(ENTRY_COUNT)) u_so_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_entry),
        .i_wdata (so_wdata),
        .i_re    (in_take),
        .i_raddr (rd_addr),
        .o_rdata (so_rdata)
    );

    // unwritten entries read as their reset values
    always_comb begin
        cur_phase   = r_ps_vld_rd ? ps_rdata[PS_W-1:TIME_W] : PH_BEFORE;
        cur_stamp   = r_ps_vld_rd ? ps_rdata[TIME_W-1:0] : '0;
        cur_off     = r_so_vld_rd ? signed'(so_rdata[OFF_W-1:0]) : '0;
        cur_started = r_so_vld_rd ? so_rdata[OFF_W] : 1'b0;
    end

    // widths, elapsed time and the scrolled offset
    always_comb begin
        icon       = (r_line == '0) && r_with_icon;
        full_w     = {1'b0, r_text_width} + (icon ? (PIX_W+1)'(r_icon_width) : '0);
        to_scroll  = signed'({1'b0, full_w}) - signed'({2'b00, r_window_width});
        neg_scroll = -(PIX_W+3)'(to_scroll);
        do_scroll  = to_scroll > 0;
        off_sub    = (OFF_W+1)'(cur_off) - signed'({{(OFF_W+1-RATE_W){1'b0}}, r_scroll_rate});
        off_sat    = (off_sub[OFF_W] != off_sub[OFF_W-1]) ? {1'b1, {(OFF_W-1){1'b0}}}
                                                          : off_sub[OFF_W-1:0];
        advance    = (r_op == OP_ADVANCE) && (int'(r_row) < MAX_ROWS)
                     && (int'(r_line) < LINES_PER_ROW);
    end

    // in the wait-before phase a stamp of zero is unset and taken fresh, so no time has passed
    always_comb begin
        if ((cur_phase == PH_BEFORE) && (cur_stamp == '0)) begin
            elapsed = '0;
        end else begin
            elapsed = r_now_ms - cur_stamp;
        end
        pause_over = elapsed >= TIME_W'(r_pause_ms);
    end

    // phase step of one entry
    always_comb begin
        new_phase   = cur_phase;
        new_stamp   = cur_stamp;
        new_off     = cur_off;
        new_started = cur_started;
        unique case (cur_phase)
            PH_BEFORE: begin
                if (do_scroll) begin
                    if (cur_stamp == '0) begin
                        new_stamp = r_now_ms;
                        new_off   = '0;
                    end
                    if (pause_over) new_phase = PH_SCROLL;
                end else begin
                    new_off = '0;
                end
            end
            PH_SCROLL: begin
                if (do_scroll) begin
                    new_off = off_sat;
                    if ((r_line != '0) && !cur_started && r_nonempty) begin
                        new_off     = '0;
                        new_started = 1'b1;
                    end
                end else if (signed'({{(OFF_W+1-PIX_W){1'b0}}, r_text_width})
                             < (OFF_W+1)'(cur_off)) begin
                    new_off     = '0;
                    new_started = 1'b0;
                end
                if ((OFF_W+1)'(new_off) <= (OFF_W+1)'(neg_scroll)) begin
                    new_stamp = r_now_ms;
                    new_phase = PH_AFTER;
                end
            end
            PH_AFTER: begin
                if (do_scroll) begin
                    if (pause_over) begin
                        new_off   = '0;
                        new_phase = PH_BEFORE;
                        new_stamp = r_now_ms;
                    end
                end else begin
                    new_off = '0;
                end
            end
            default: ;
        endcase
    end

    // write back and result selection
    always_comb begin
        mem_we   = calc_done && advance && (r_window_width != '0);
        ps_wdata = {new_phase, new_stamp};
        so_wdata = {new_started, new_off};
        res_off   = '0;
        res_phase = PH_BEFORE;
        res_icon  = 1'b0;
        if (advance) begin
            if (r_window_width == '0) begin
                res_off   = cur_off;
                res_phase = cur_phase;
            end else begin
                res_off   = new_off;
                res_phase = new_phase;
                res_icon  = icon;
            end
        end
    end

    // entries of the addressed row
    always_comb begin
        row_mask = '0;
        for (int l = 0; l < LINES_PER_ROW; l++) begin
            row_mask[entry_idx(r_row, LINE_W'(l))] = 1'b1;
        end
    end

    // written marks: write-back sets them, reset clears all, row and all-row requests clear offsets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps_vld <= '0;
            r_so_vld <= '0;
        end else if (calc_done) begin
            if (mem_we) begin
                r_ps_vld[r_entry] <= 1'b1;
                r_so_vld[r_entry] <= 1'b1;
            end else if (r_op == OP_RESET_ALL) begin
                r_so_vld <= '0;
            end else if ((r_op == OP_RESET_ROW) && (int'(r_row) < MAX_ROWS)) begin
                r_so_vld <= r_so_vld & ~row_mask;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (calc_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (calc_done) begin
            r_out_off   <= res_off;
            r_out_phase <= res_phase;
            r_out_icon  <= res_icon;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_scroll_offset = r_out_off;
    assign o_phase         = r_out_phase;
    assign o_icon_shown    = r_out_icon;

endmodule

@@ rtl/core/mcs_checker.sv @@
module mcs_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic signed [mcs_pkg::OFF_W-1:0] o_scroll_offset,
    input logic [mcs_pkg::PHASE_W-1:0]      o_phase,
    input logic                             o_icon_shown
);
    import mcs_pkg::*;

    // a taken request keeps the block busy until its write-back
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken on consecutive cycles");

    // a new result only follows a request in progress
    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a request in progress");

    // a result is issued only after a request has been taken
    a_result_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_out_valid) && $past(i_rst_n)) |-> $past(o_in_stall) && $past(o_in_stall, 2)
            || $past(i_in_valid, 2))
        else $error("result without an accepted request");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_scroll_offset)
            && $stable(o_phase) && $stable(o_icon_shown))
        else $error("stalled result changed");

endmodule

bind marquee_scroll_controller mcs_checker u_mcs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_scroll_offset (o_scroll_offset),
    .o_phase         (o_phase),
    .o_icon_shown    (o_icon_shown)
);
